@@ rtl/bpa_pkg.sv @@
// Shared constants, codes and types of the buddy page allocator.
package bpa_pkg;

   localparam int TABLE_ENTRIES = 1024;
   localparam int ORDER_COUNT   = 11;
   localparam int PAGE_NUM_BITS = 20;

   localparam int IDX_W   = $clog2(TABLE_ENTRIES);
   localparam int LINK_W  = IDX_W + 1;
   localparam int CNT_W   = IDX_W + 1;
   localparam int SIZE_W  = 21;
   localparam int REQ_W   = 16;
   localparam int SPLIT_W = 16;
   localparam int K_W     = 5;
   localparam int CMP_W   = (CNT_W > K_W) ? CNT_W : K_W;
   localparam int CSR_A_W = 2;

   localparam logic [LINK_W-1:0]  NIL       = LINK_W'(TABLE_ENTRIES);
   localparam logic [REQ_W-1:0]   MAX_REQ   = REQ_W'(1 << (ORDER_COUNT - 1));
   localparam logic [SPLIT_W-1:0] SPLIT_CAP = SPLIT_W'(32768);

   // operation codes
   localparam logic [1:0] FUNC_ALLOC = 2'd0;
   localparam logic [1:0] FUNC_FREE  = 2'd1;
   localparam logic [1:0] FUNC_INIT  = 2'd2;

   // result status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_SIZE  = 3'd1;
   localparam logic [2:0] ST_NO_FIT    = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;

   // register indexes
   localparam logic [CSR_A_W-1:0] CSR_A_START = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_A_PAGES = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_B_START = 2'd2;
   localparam logic [CSR_A_W-1:0] CSR_B_PAGES = 2'd3;

   typedef struct packed {
      logic [1:0]               func;
      logic [REQ_W-1:0]         req_pages;
      logic [PAGE_NUM_BITS-1:0] free_page;
   } req_type;

   typedef struct packed {
      logic [2:0]               status;
      logic [PAGE_NUM_BITS-1:0] page;
   } rsp_type;

   typedef struct packed {
      logic [PAGE_NUM_BITS-1:0] a_start;
      logic [SIZE_W-1:0]        a_pages;
      logic [PAGE_NUM_BITS-1:0] b_start;
      logic [SIZE_W-1:0]        b_pages;
   } cfg_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_DISP, OP_RD, OP_RDNX, OP_ACHK, OP_PINIT, OP_PSTEP,
      OP_KSTEP, OP_CAP, OP_POP, OP_PWR, OP_PLNK, OP_FITWR, OP_FCHK, OP_MCHK,
      OP_NOTFOUND, OP_INITA, OP_INITB, OP_INITL, OP_OUT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       f_ok;
      logic       cur_nil;
      logic       hit;
      logic       fit_found;
      logic       p_done;
      logic       k_done;
      logic       full;
      logic       last_piece;
      logic       match;
      logic       link_nil;
      logic       merge;
      logic       need_il;
      logic       rsp_free;
   } sts_type;

endpackage

@@ rtl/buddy_page_allocator_top.sv @@
// Top level of the buddy page allocator: region registers, sequencer and datapath.
// An alloc walks the list chunk by chunk, then sizes a carve and writes the carved pieces;
// a free walks the list chunk by chunk, then merges; init writes the two regions.
// Each also goes through dispatch and result hand-off.
// One transaction at a time: req_stall stays high until the result has been handed off.
// Reset (synchronous) empties the list and slot pool at once; no clearing pass.
module buddy_page_allocator_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  bpa_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output bpa_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_we,
   input  logic [bpa_pkg::CSR_A_W-1:0]          csr_addr,
   input  logic [bpa_pkg::SIZE_W-1:0]           csr_wdata
);

   bpa_pkg::cfg_type cfg_ff, cfg_in;
   bpa_pkg::cmd_type cmd;
   bpa_pkg::sts_type sts;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            bpa_pkg::CSR_A_START: cfg_in.a_start = csr_wdata[bpa_pkg::PAGE_NUM_BITS-1:0];
            bpa_pkg::CSR_A_PAGES: cfg_in.a_pages = csr_wdata;
            bpa_pkg::CSR_B_START: cfg_in.b_start = csr_wdata[bpa_pkg::PAGE_NUM_BITS-1:0];
            bpa_pkg::CSR_B_PAGES: cfg_in.b_pages = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.a_start <= bpa_pkg::PAGE_NUM_BITS'(0);
         cfg_ff.a_pages <= bpa_pkg::SIZE_W'(159);
         cfg_ff.b_start <= bpa_pkg::PAGE_NUM_BITS'(256);
         cfg_ff.b_pages <= bpa_pkg::SIZE_W'(7664);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bpa_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/bpa_ctrl.sv @@
// Sequencer of the buddy page allocator: walks, sizing, carving, merging, init.
module bpa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bpa_pkg::sts_type sts,
   output bpa_pkg::cmd_type cmd
);

   typedef enum logic [19:0] {
      S_IDLE   = 20'h00001,
      S_DISP   = 20'h00002,
      S_A_RD   = 20'h00004,
      S_A_CHK  = 20'h00008,
      S_A_END  = 20'h00010,
      S_A_P    = 20'h00020,
      S_A_K    = 20'h00040,
      S_A_CAP  = 20'h00080,
      S_POP    = 20'h00100,
      S_PWR    = 20'h00200,
      S_PLNK   = 20'h00400,
      S_FIT    = 20'h00800,
      S_F_RD   = 20'h01000,
      S_F_CHK  = 20'h02000,
      S_M_RD   = 20'h04000,
      S_M_CHK  = 20'h08000,
      S_INIT_A = 20'h10000,
      S_INIT_B = 20'h20000,
      S_INIT_L = 20'h40000,
      S_DONE   = 20'h80000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = bpa_pkg::OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = bpa_pkg::OP_LOAD;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            cmd.op = bpa_pkg::OP_DISP;
            unique case (sts.func)
               bpa_pkg::FUNC_ALLOC: state_in = sts.f_ok ? S_A_RD : S_DONE;
               bpa_pkg::FUNC_FREE:  state_in = S_F_RD;
               bpa_pkg::FUNC_INIT:  state_in = S_INIT_A;
               default:             state_in = S_DONE;
            endcase
         end
         S_A_RD: begin
            if (sts.cur_nil) begin
               state_in = S_A_END;
            end else begin
               cmd.op   = bpa_pkg::OP_RD;
               state_in = S_A_CHK;
            end
         end
         S_A_CHK: begin
            cmd.op   = bpa_pkg::OP_ACHK;
            state_in = sts.hit ? S_DONE : S_A_RD;
         end
         S_A_END: begin
            cmd.op   = bpa_pkg::OP_PINIT;
            state_in = sts.fit_found ? S_A_P : S_DONE;
         end
         S_A_P: begin
            cmd.op   = bpa_pkg::OP_PSTEP;
            state_in = sts.p_done ? S_A_K : S_A_P;
         end
         S_A_K: begin
            cmd.op   = bpa_pkg::OP_KSTEP;
            state_in = sts.k_done ? S_A_CAP : S_A_K;
         end
         S_A_CAP: begin
            cmd.op   = bpa_pkg::OP_CAP;
            state_in = sts.full ? S_DONE : S_POP;
         end
         S_POP: begin
            cmd.op   = bpa_pkg::OP_POP;
            state_in = S_PWR;
         end
         S_PWR: begin
            cmd.op   = bpa_pkg::OP_PWR;
            state_in = S_PLNK;
         end
         S_PLNK: begin
            cmd.op   = bpa_pkg::OP_PLNK;
            state_in = sts.last_piece ? S_FIT : S_POP;
         end
         S_FIT: begin
            cmd.op   = bpa_pkg::OP_FITWR;
            state_in = S_DONE;
         end
         S_F_RD: begin
            if (sts.cur_nil) begin
               cmd.op   = bpa_pkg::OP_NOTFOUND;
               state_in = S_DONE;
            end else begin
               cmd.op   = bpa_pkg::OP_RD;
               state_in = S_F_CHK;
            end
         end
         S_F_CHK: begin
            cmd.op   = bpa_pkg::OP_FCHK;
            state_in = sts.match ? S_M_RD : S_F_RD;
         end
         S_M_RD: begin
            if (sts.link_nil) begin
               state_in = S_DONE;
            end else begin
               cmd.op   = bpa_pkg::OP_RDNX;
               state_in = S_M_CHK;
            end
         end
         S_M_CHK: begin
            cmd.op   = bpa_pkg::OP_MCHK;
            state_in = sts.merge ? S_M_RD : S_DONE;
         end
         S_INIT_A: begin
            cmd.op   = bpa_pkg::OP_INITA;
            state_in = S_INIT_B;
         end
         S_INIT_B: begin
            cmd.op   = bpa_pkg::OP_INITB;
            state_in = sts.need_il ? S_INIT_L : S_DONE;
         end
         S_INIT_L: begin
            cmd.op   = bpa_pkg::OP_INITL;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.op   = bpa_pkg::OP_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

@@ rtl/bpa_dpath.sv @@
// Datapath of the buddy page allocator: chunk tables, slot stack, walk registers.
module bpa_dpath (
   input  logic             clock,
   input  logic             reset,
   input  bpa_pkg::cmd_type cmd,
   output bpa_pkg::sts_type sts,
   input  bpa_pkg::req_type req_data,
   input  bpa_pkg::cfg_type cfg,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bpa_pkg::rsp_type rsp_data
);

   localparam int PW = bpa_pkg::PAGE_NUM_BITS;
   localparam int SW = bpa_pkg::SIZE_W;
   localparam int IW = bpa_pkg::IDX_W;
   localparam int LW = bpa_pkg::LINK_W;
   localparam int CW = bpa_pkg::CNT_W;
   localparam int PS = bpa_pkg::SPLIT_W;
   localparam int KW = bpa_pkg::K_W;
   localparam int MW = bpa_pkg::CMP_W;

   typedef struct packed {
      logic [PW-1:0] start;
      logic [SW-1:0] size;
      logic          free;
   } entry_type;

   entry_type     data_mem  [bpa_pkg::TABLE_ENTRIES];
   logic [LW-1:0] link_mem  [bpa_pkg::TABLE_ENTRIES];
   logic [IW-1:0] stack_mem [bpa_pkg::TABLE_ENTRIES];

   entry_type     data_q;
   logic [LW-1:0] link_q;
   logic [IW-1:0] stack_q;

   // memory ports
   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic          dw_en;
   logic [IW-1:0] dw_addr;
   entry_type     dw_data;
   logic          lw_en;
   logic [IW-1:0] lw_addr;
   logic [LW-1:0] lw_data;
   logic          sw_en;
   logic [IW-1:0] sw_addr;
   logic          sr_en;
   logic [IW-1:0] sr_addr;

   logic [1:0]       func_ff, func_in;
   logic             fok_ff, fok_in;
   logic [SW-1:0]    f_ff, f_in;
   logic [PW-1:0]    page_ff, page_in;
   logic [LW-1:0]    cur_ff, cur_in;
   logic [LW-1:0]    prev_ff, prev_in;
   logic [LW-1:0]    link_ff, link_in;
   logic [LW-1:0]    fit_ff, fit_in;
   logic [LW-1:0]    fitprev_ff, fitprev_in;
   logic             found_ff, found_in;
   logic [PW-1:0]    fstart_ff, fstart_in;
   logic [SW-1:0]    fsize_ff, fsize_in;
   logic [PS-1:0]    p_ff, p_in;
   logic [PS-1:0]    t_ff, t_in;
   logic [KW-1:0]    k_ff, k_in;
   logic [KW-1:0]    i_ff, i_in;
   logic [PW-1:0]    off_ff, off_in;
   logic [SW-1:0]    sz_ff, sz_in;
   logic [LW-1:0]    lfrom_ff, lfrom_in;
   logic [IW-1:0]    slot_ff, slot_in;
   logic             popstk_ff, popstk_in;
   logic [PW-1:0]    cstart_ff, cstart_in;
   logic [SW-1:0]    csize_ff, csize_in;
   logic [LW-1:0]    head_ff, head_in;
   logic [CW-1:0]    hw_ff, hw_in;
   logic [CW-1:0]    scnt_ff, scnt_in;
   logic [2:0]       stat_ff, stat_in;
   logic [PW-1:0]    rpage_ff, rpage_in;
   logic             rsp_valid_ff, rsp_valid_in;
   bpa_pkg::rsp_type rsp_ff, rsp_in;

   logic [CW-1:0]    free_cnt;
   logic             p_grow;
   logic [IW-1:0]    slot_now;

   assign free_cnt = CW'(bpa_pkg::TABLE_ENTRIES) - hw_ff + scnt_ff;
   assign p_grow   = (SW'({p_ff, 1'b0}) < fsize_ff) && (p_ff < bpa_pkg::SPLIT_CAP);
   assign slot_now = popstk_ff ? stack_q : slot_ff;

   // status towards the sequencer
   always_comb begin
      sts.func       = func_ff;
      sts.f_ok       = fok_ff;
      sts.cur_nil    = (cur_ff == bpa_pkg::NIL);
      sts.hit        = data_q.free && (data_q.size == f_ff);
      sts.fit_found  = found_ff;
      sts.p_done     = !p_grow;
      sts.k_done     = !(t_ff < p_ff);
      sts.full       = (MW'(free_cnt) < MW'(k_ff));
      sts.last_piece = (i_ff == k_ff - KW'(1));
      sts.match      = (data_q.start == page_ff);
      sts.link_nil   = (link_ff == bpa_pkg::NIL);
      sts.merge      = data_q.free && (data_q.size == csize_ff) &&
                       ((cstart_ff + csize_ff[PW-1:0]) == data_q.start) &&
                       !csize_ff[SW-1];
      sts.need_il    = (cfg.b_pages != '0) && (hw_ff != '0);
      sts.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      func_in = func_ff;   fok_in = fok_ff;     f_in = f_ff;       page_in = page_ff;
      cur_in = cur_ff;     prev_in = prev_ff;   link_in = link_ff;
      fit_in = fit_ff;     fitprev_in = fitprev_ff;  found_in = found_ff;
      fstart_in = fstart_ff;  fsize_in = fsize_ff;
      p_in = p_ff;  t_in = t_ff;  k_in = k_ff;  i_in = i_ff;
      off_in = off_ff;  sz_in = sz_ff;  lfrom_in = lfrom_ff;
      slot_in = slot_ff;  popstk_in = popstk_ff;
      cstart_in = cstart_ff;  csize_in = csize_ff;
      head_in = head_ff;  hw_in = hw_ff;  scnt_in = scnt_ff;
      stat_in = stat_ff;  rpage_in = rpage_ff;  rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rd_en = 1'b0;  rd_addr = cur_ff[IW-1:0];
      dw_en = 1'b0;  dw_addr = cur_ff[IW-1:0];  dw_data = data_q;
      lw_en = 1'b0;  lw_addr = cur_ff[IW-1:0];  lw_data = bpa_pkg::NIL;
      sw_en = 1'b0;  sw_addr = scnt_ff[IW-1:0];
      sr_en = 1'b0;  sr_addr = IW'(scnt_ff - CW'(1));

      case (cmd.op)
         bpa_pkg::OP_LOAD: begin
            func_in  = req_data.func;
            fok_in   = (req_data.req_pages != '0) &&
                       ((req_data.req_pages & (req_data.req_pages - 16'd1)) == '0) &&
                       (req_data.req_pages <= bpa_pkg::MAX_REQ);
            f_in     = SW'(req_data.req_pages);
            page_in  = req_data.free_page;
            cur_in   = head_ff;
            prev_in  = bpa_pkg::NIL;
            found_in = 1'b0;
            stat_in  = bpa_pkg::ST_OK;
            rpage_in = '0;
         end
         bpa_pkg::OP_DISP: begin
            if (func_ff == bpa_pkg::FUNC_ALLOC && !fok_ff) stat_in = bpa_pkg::ST_BAD_SIZE;
         end
         bpa_pkg::OP_RD: begin
            rd_en   = 1'b1;
            rd_addr = cur_ff[IW-1:0];
         end
         bpa_pkg::OP_RDNX: begin
            rd_en   = 1'b1;
            rd_addr = link_ff[IW-1:0];
         end
         bpa_pkg::OP_ACHK: begin
            if (sts.hit) begin
               dw_en        = 1'b1;
               dw_data      = data_q;
               dw_data.free = 1'b0;
               rpage_in     = data_q.start;
            end else begin
               if (data_q.free && data_q.size > f_ff && !found_ff) begin
                  found_in   = 1'b1;
                  fit_in     = cur_ff;
                  fitprev_in = prev_ff;
                  fstart_in  = data_q.start;
                  fsize_in   = data_q.size;
               end
               prev_in = cur_ff;
               cur_in  = link_q;
            end
         end
         bpa_pkg::OP_PINIT: begin
            if (!found_ff) stat_in = bpa_pkg::ST_NO_FIT;
            p_in = PS'(1);
            t_in = PS'(f_ff);
            k_in = KW'(1);
         end
         bpa_pkg::OP_PSTEP: begin
            if (p_grow) p_in = {p_ff[PS-2:0], 1'b0};
         end
         bpa_pkg::OP_KSTEP: begin
            if (t_ff < p_ff) begin
               t_in = {t_ff[PS-2:0], 1'b0};
               k_in = k_ff + KW'(1);
            end
         end
         bpa_pkg::OP_CAP: begin
            if (sts.full) stat_in = bpa_pkg::ST_FULL;
            i_in     = '0;
            off_in   = '0;
            sz_in    = f_ff;
            lfrom_in = fitprev_ff;
         end
         bpa_pkg::OP_POP: begin
            // reuse a released slot first, else take a never-used one
            if (scnt_ff != '0) begin
               sr_en     = 1'b1;
               scnt_in   = scnt_ff - CW'(1);
               popstk_in = 1'b1;
            end else begin
               slot_in   = hw_ff[IW-1:0];
               hw_in     = hw_ff + CW'(1);
               popstk_in = 1'b0;
            end
         end
         bpa_pkg::OP_PWR: begin
            dw_en         = 1'b1;
            dw_addr       = slot_now;
            dw_data.start = fstart_ff + off_ff;
            dw_data.size  = sz_ff;
            dw_data.free  = (i_ff != '0);
            lw_en         = 1'b1;
            lw_addr       = slot_now;
            lw_data       = fit_ff;
            slot_in       = slot_now;
            off_in        = off_ff + sz_ff[PW-1:0];
            if (i_ff != '0) sz_in = {sz_ff[SW-2:0], 1'b0};
         end
         bpa_pkg::OP_PLNK: begin
            if (lfrom_ff == bpa_pkg::NIL) begin
               head_in = LW'(slot_ff);
            end else begin
               lw_en   = 1'b1;
               lw_addr = lfrom_ff[IW-1:0];
               lw_data = LW'(slot_ff);
            end
            lfrom_in = LW'(slot_ff);
            i_in     = i_ff + KW'(1);
         end
         bpa_pkg::OP_FITWR: begin
            dw_en         = 1'b1;
            dw_addr       = fit_ff[IW-1:0];
            dw_data.start = fstart_ff + PW'(p_ff);
            dw_data.size  = fsize_ff - SW'(p_ff);
            dw_data.free  = 1'b1;
            rpage_in      = fstart_ff;
         end
         bpa_pkg::OP_NOTFOUND: stat_in = bpa_pkg::ST_NOT_FOUND;
         bpa_pkg::OP_FCHK: begin
            if (sts.match) begin
               dw_en        = 1'b1;
               dw_data      = data_q;
               dw_data.free = 1'b1;
               cstart_in    = data_q.start;
               csize_in     = data_q.size;
               link_in      = link_q;
            end else begin
               prev_in = cur_ff;
               cur_in  = link_q;
            end
         end
         bpa_pkg::OP_MCHK: begin
            if (sts.merge) begin
               dw_en         = 1'b1;
               dw_addr       = link_ff[IW-1:0];
               dw_data.start = cstart_ff;
               dw_data.size  = {csize_ff[SW-2:0], 1'b0};
               dw_data.free  = 1'b1;
               if (prev_ff == bpa_pkg::NIL) begin
                  head_in = link_ff;
               end else begin
                  lw_en   = 1'b1;
                  lw_addr = prev_ff[IW-1:0];
                  lw_data = link_ff;
               end
               // the absorbed slot goes back on the stack
               sw_en    = 1'b1;
               scnt_in  = scnt_ff + CW'(1);
               cur_in   = link_ff;
               csize_in = {csize_ff[SW-2:0], 1'b0};
               link_in  = link_q;
            end
         end
         bpa_pkg::OP_INITA: begin
            head_in = bpa_pkg::NIL;
            hw_in   = '0;
            scnt_in = '0;
            if (cfg.a_pages != '0) begin
               dw_en         = 1'b1;
               dw_addr       = '0;
               dw_data.start = cfg.a_start;
               dw_data.size  = cfg.a_pages;
               dw_data.free  = 1'b1;
               lw_en         = 1'b1;
               lw_addr       = '0;
               lw_data       = bpa_pkg::NIL;
               head_in       = '0;
               hw_in         = CW'(1);
            end
         end
         bpa_pkg::OP_INITB: begin
            if (cfg.b_pages != '0) begin
               dw_en         = 1'b1;
               dw_addr       = hw_ff[IW-1:0];
               dw_data.start = cfg.b_start;
               dw_data.size  = cfg.b_pages;
               dw_data.free  = 1'b1;
               lw_en         = 1'b1;
               lw_addr       = hw_ff[IW-1:0];
               lw_data       = bpa_pkg::NIL;
               hw_in         = hw_ff + CW'(1);
               if (hw_ff == '0) head_in = '0;
            end
         end
         bpa_pkg::OP_INITL: begin
            lw_en   = 1'b1;
            lw_addr = '0;
            lw_data = LW'(1);
         end
         bpa_pkg::OP_OUT: begin
            rsp_valid_in  = 1'b1;
            rsp_in.status = stat_ff;
            rsp_in.page   = (stat_ff == bpa_pkg::ST_OK) ? rpage_ff : '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_q <= data_mem[rd_addr];
         link_q <= link_mem[rd_addr];
      end
      if (dw_en) data_mem[dw_addr] <= dw_data;
      if (lw_en) link_mem[lw_addr] <= lw_data;
      if (sr_en) stack_q <= stack_mem[sr_addr];
      if (sw_en) stack_mem[sw_addr] <= cur_ff[IW-1:0];
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;   fok_ff <= fok_in;     f_ff <= f_in;     page_ff <= page_in;
      cur_ff <= cur_in;     prev_ff <= prev_in;   link_ff <= link_in;
      fit_ff <= fit_in;     fitprev_ff <= fitprev_in;  found_ff <= found_in;
      fstart_ff <= fstart_in;  fsize_ff <= fsize_in;
      p_ff <= p_in;  t_ff <= t_in;  k_ff <= k_in;  i_ff <= i_in;
      off_ff <= off_in;  sz_ff <= sz_in;  lfrom_ff <= lfrom_in;
      slot_ff <= slot_in;  popstk_ff <= popstk_in;
      cstart_ff <= cstart_in;  csize_ff <= csize_in;
      stat_ff <= stat_in;  rpage_ff <= rpage_in;  rsp_ff <= rsp_in;
      if (reset) begin
         head_ff      <= bpa_pkg::NIL;
         hw_ff        <= '0;
         scnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         hw_ff        <= hw_in;
         scnt_ff      <= scnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_stack_le_hw: assert property (@(posedge clock) disable iff (reset)
      scnt_ff <= hw_ff) else $error("released slot count above high-water mark");
   a_hw_le_n: assert property (@(posedge clock) disable iff (reset)
      hw_ff <= CW'(bpa_pkg::TABLE_ENTRIES)) else $error("slot high-water mark overflow");
   a_piece_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == bpa_pkg::OP_PWR) |-> (CW'(slot_now) < hw_ff))
      else $error("carved piece written to a slot never handed out");
   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == bpa_pkg::OP_OUT) |=> rsp_valid_ff) else $error("result transaction lost");
`endif

endmodule
